### hdl/rws_pkg.sv
`timescale 1ns / 1ps

package rws_pkg;

	localparam int TOTAL_BITS       = 24;
	localparam int FIT_BITS         = 16;
	localparam int IDX_BITS         = 8;
	localparam int POP_BITS         = 9;
	localparam int DEF_MAX_POP      = 256;
	localparam int DEF_FITNESS_BITS = 16;

	localparam logic [POP_BITS-1:0]   POP_RESET   = 9'd256;
	localparam logic [TOTAL_BITS-1:0] TOTAL_SAT   = 24'hFFFFFF;
	localparam logic [FIT_BITS-1:0]   FIT_MAX_VAL = 16'hFFFF;

	localparam logic [1:0] FUNC_CLEAR  = 2'd0;
	localparam logic [1:0] FUNC_LOAD   = 2'd1;
	localparam logic [1:0] FUNC_SELECT = 2'd2;

	localparam logic [1:0] ST_OK    = 2'd0;
	localparam logic [1:0] ST_FULL  = 2'd1;
	localparam logic [1:0] ST_EMPTY = 2'd2;

	typedef struct packed {
		logic [1:0]          func;
		logic [FIT_BITS-1:0] fitness_value;
		logic [FIT_BITS-1:0] random_fraction;
	} item_t;

	typedef struct packed {
		logic [IDX_BITS-1:0]   chosen_index;
		logic [TOTAL_BITS-1:0] total_fitness;
		logic [FIT_BITS-1:0]   best_fitness;
		logic [IDX_BITS-1:0]   best_index;
		logic [FIT_BITS-1:0]   worst_fitness;
		logic [FIT_BITS-1:0]   average_fitness;
		logic [1:0]            status;
	} result_t;

endpackage

### hdl/roulette_wheel_selector.sv
`timescale 1ns / 1ps
// channel   direction  handshake              payload
// item      in         item_valid/item_stall  item (func, fitness_value, random_fraction)
// result    out        result_valid/result_stall  result (statistics, chosen_index, status)
// cfg       in         cfg_valid/cfg_ready    cfg_data (pop_size)
//
// clear, load and unused codes pass through exec, divider start, divide and finish.
// a select also walks the stored entries in order through the single registered
// read port, until the running sum reaches the slice or the last loaded entry.
// the average comes from a 24-step restoring divider run after every item.
// arst_n clears the statistics and sets pop_size to 256; the store is not cleared.
// a new item is taken while the previous result waits under result_stall.
module roulette_wheel_selector #(
	parameter int MAX_POP      = rws_pkg::DEF_MAX_POP,
	parameter int FITNESS_BITS = rws_pkg::DEF_FITNESS_BITS
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          item_valid,
	output logic                          item_stall,
	input  rws_pkg::item_t                item,
	output logic                          result_valid,
	input  logic                          result_stall,
	output rws_pkg::result_t              result,
	input  logic                          cfg_valid,
	output logic                          cfg_ready,
	input  logic [rws_pkg::POP_BITS-1:0]  cfg_data
);
	import rws_pkg::*;

	localparam int SW   = (FITNESS_BITS < FIT_BITS) ? FITNESS_BITS : FIT_BITS;
	localparam int IW   = $clog2(MAX_POP);
	localparam int CW   = $clog2(MAX_POP + 1);
	localparam int SUMW = (SW + IW > TOTAL_BITS) ? SW + IW : TOTAL_BITS;
	localparam int DCW  = $clog2(TOTAL_BITS);

	localparam logic [2:0] S_IDLE   = 3'd0;
	localparam logic [2:0] S_EXEC   = 3'd1;
	localparam logic [2:0] S_WALK   = 3'd2;
	localparam logic [2:0] S_DSTART = 3'd3;
	localparam logic [2:0] S_DIV    = 3'd4;
	localparam logic [2:0] S_FINISH = 3'd5;

	logic [2:0]            state_q;
	item_t                 cmd_q;
	logic [POP_BITS-1:0]   pop_size_q;
	logic [CW-1:0]         loaded_count_q;
	logic [TOTAL_BITS-1:0] running_total_q;
	logic [FIT_BITS-1:0]   best_q;
	logic [IW-1:0]         best_pos_q;
	logic [FIT_BITS-1:0]   worst_q;
	logic [IDX_BITS-1:0]   chosen_q;
	logic [1:0]            status_q;
	logic [TOTAL_BITS-1:0] slice_q;
	logic [SUMW-1:0]       sum_q;
	logic [CW-1:0]         walk_idx_q;
	logic                  rd_pend_s1;
	logic [IW-1:0]         rd_idx_s1;
	logic [POP_BITS-1:0]   div_rem_q;
	logic [TOTAL_BITS-1:0] div_quo_q;
	logic [DCW-1:0]        div_cnt_q;
	logic                  result_valid_q;
	result_t               result_q;

	logic [SW-1:0]         fitness_mem [MAX_POP];
	logic [SW-1:0]         rd_data_q;

	logic [POP_BITS-1:0]   eff_pop;
	logic                  table_full;
	logic [SW-1:0]         fit;
	logic [TOTAL_BITS:0]   load_sum;
	logic                  mem_we;
	logic [IW-1:0]         rd_addr;
	logic                  issue;
	logic [SUMW-1:0]       sum_next;
	logic                  walk_hit;
	logic [POP_BITS:0]     rem_sh;
	logic                  q_bit;
	logic [FIT_BITS-1:0]   avg;
	logic [TOTAL_BITS+FIT_BITS-1:0] prod;

	always_comb begin
		if (pop_size_q == '0) begin
			eff_pop = POP_BITS'(1);
		end else if (32'(pop_size_q) > MAX_POP) begin
			eff_pop = POP_BITS'(MAX_POP);
		end else begin
			eff_pop = pop_size_q;
		end
	end

	assign table_full = (32'(loaded_count_q) >= 32'(eff_pop)) ||
	                    (32'(loaded_count_q) >= MAX_POP);
	assign fit        = cmd_q.fitness_value[SW-1:0];
	assign load_sum   = {1'b0, running_total_q} + (TOTAL_BITS+1)'(fit);
	assign mem_we     = (state_q == S_EXEC) && (cmd_q.func == FUNC_LOAD) && !table_full;
	assign prod       = (TOTAL_BITS+FIT_BITS)'(cmd_q.random_fraction) *
	                    (TOTAL_BITS+FIT_BITS)'(running_total_q);

	assign issue      = (state_q == S_WALK) && (walk_idx_q < loaded_count_q);
	assign rd_addr    = walk_idx_q[IW-1:0];
	assign sum_next   = sum_q + SUMW'(rd_data_q);
	assign walk_hit   = (sum_next >= SUMW'(slice_q)) ||
	                    (CW'(rd_idx_s1) == loaded_count_q - CW'(1));

	assign rem_sh     = {div_rem_q, div_quo_q[TOTAL_BITS-1]};
	assign q_bit      = rem_sh >= {1'b0, eff_pop};
	assign avg        = (div_quo_q[TOTAL_BITS-1:FIT_BITS] != '0) ? FIT_MAX_VAL
	                    : div_quo_q[FIT_BITS-1:0];

	assign item_stall   = (state_q != S_IDLE);
	assign cfg_ready    = 1'b1;
	assign result_valid = result_valid_q;
	assign result       = result_q;

	always_ff @(posedge clk) begin
		if (mem_we) begin
			fitness_mem[loaded_count_q[IW-1:0]] <= fit;
		end
		rd_data_q <= fitness_mem[rd_addr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q         <= S_IDLE;
			pop_size_q      <= POP_RESET;
			loaded_count_q  <= '0;
			running_total_q <= '0;
			best_q          <= '0;
			best_pos_q      <= '0;
			worst_q         <= FIT_MAX_VAL;
			rd_pend_s1      <= 1'b0;
			result_valid_q  <= 1'b0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				pop_size_q <= cfg_data;
			end
			if (result_valid_q && !result_stall) begin
				result_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (item_valid) begin
						cmd_q   <= item;
						state_q <= S_EXEC;
					end
				end
				S_EXEC: begin
					chosen_q <= '0;
					status_q <= ST_OK;
					state_q  <= S_DSTART;
					unique case (cmd_q.func)
						FUNC_CLEAR: begin
							loaded_count_q  <= '0;
							running_total_q <= '0;
							best_q          <= '0;
							best_pos_q      <= '0;
							worst_q         <= FIT_MAX_VAL;
						end
						FUNC_LOAD: begin
							if (table_full) begin
								status_q <= ST_FULL;
							end else begin
								if (FIT_BITS'(fit) > best_q) begin
									best_q     <= FIT_BITS'(fit);
									best_pos_q <= loaded_count_q[IW-1:0];
								end
								if (FIT_BITS'(fit) < worst_q) begin
									worst_q <= FIT_BITS'(fit);
								end
								running_total_q <= load_sum[TOTAL_BITS] ? TOTAL_SAT
								                   : load_sum[TOTAL_BITS-1:0];
								loaded_count_q  <= loaded_count_q + CW'(1);
							end
						end
						FUNC_SELECT: begin
							if (loaded_count_q == '0) begin
								status_q <= ST_EMPTY;
							end else begin
								slice_q    <= prod[TOTAL_BITS+FIT_BITS-1:FIT_BITS];
								sum_q      <= '0;
								walk_idx_q <= '0;
								rd_pend_s1 <= 1'b0;
								state_q    <= S_WALK;
							end
						end
						default: begin
						end
					endcase
				end
				S_WALK: begin
					rd_pend_s1 <= issue;
					if (issue) begin
						rd_idx_s1  <= walk_idx_q[IW-1:0];
						walk_idx_q <= walk_idx_q + CW'(1);
					end
					if (rd_pend_s1) begin
						sum_q <= sum_next;
						if (walk_hit) begin
							chosen_q   <= IDX_BITS'(rd_idx_s1);
							rd_pend_s1 <= 1'b0;
							state_q    <= S_DSTART;
						end
					end
				end
				S_DSTART: begin
					div_rem_q <= '0;
					div_quo_q <= running_total_q;
					div_cnt_q <= '0;
					state_q   <= S_DIV;
				end
				S_DIV: begin
					div_rem_q <= q_bit ? POP_BITS'(rem_sh - {1'b0, eff_pop})
					             : rem_sh[POP_BITS-1:0];
					div_quo_q <= {div_quo_q[TOTAL_BITS-2:0], q_bit};
					div_cnt_q <= div_cnt_q + DCW'(1);
					if (div_cnt_q == DCW'(TOTAL_BITS - 1)) begin
						state_q <= S_FINISH;
					end
				end
				S_FINISH: begin
					if (!result_valid_q || !result_stall) begin
						result_q.chosen_index    <= chosen_q;
						result_q.total_fitness   <= running_total_q;
						result_q.best_fitness    <= best_q;
						result_q.best_index      <= IDX_BITS'(best_pos_q);
						result_q.worst_fitness   <= worst_q;
						result_q.average_fitness <= avg;
						result_q.status          <= status_q;
						result_valid_q           <= 1'b1;
						state_q                  <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	a_total_covers_best: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_IDLE) |-> (running_total_q >= TOTAL_BITS'(best_q)))
		else $error("running total below best fitness");

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		32'(loaded_count_q) <= MAX_POP)
		else $error("loaded count beyond store depth");

	a_walk_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_WALK) |-> (walk_idx_q <= loaded_count_q))
		else $error("walk ran past loaded entries");

	a_empty_index: assert property (@(posedge clk) disable iff (!arst_n)
		(result_valid && (result.status == ST_EMPTY)) |-> (result.chosen_index == '0))
		else $error("empty select gave a nonzero index");

	a_result_source: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(result_valid_q) |-> ($past(state_q) == S_FINISH))
		else $error("result beat raised outside finish");

endmodule
